/* sv/sdtp_pkg.sv */
// ============================================================================
// Delay timer pool package
// Shared types and command codes for the delay timer pool and its slot cells.
// ============================================================================
`default_nettype none

package sdtp_pkg;

    // Command codes carried in the command field of an input transaction.
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_ALLOC   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    // Field widths fixed by the interface.
    localparam int DELAY_W  = 24;
    localparam int INDEX_W  = 4;
    localparam int PERIOD_W = 16;

    // Divider period after reset.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd500;

    // One input transaction.
    typedef struct packed {
        logic [1:0]         command;
        logic [DELAY_W-1:0] delay_ticks;
        logic [INDEX_W-1:0] slot_index;
    } t_cmd_item;

    // One result transaction.
    typedef struct packed {
        logic               granted;
        logic [INDEX_W-1:0] granted_slot;
        logic               slot_done;
        logic               period_flag;
    } t_result_item;

    // Broadcast controls from the sequencer to every slot cell.
    typedef struct packed {
        logic               tick;
        logic               rel_en;
        logic [INDEX_W-1:0] slot_index;
    } t_cell_ctrl;

endpackage

`default_nettype wire

/* sv/sdtp_cell.sv */
// ============================================================================
// Delay timer pool slot cell
// One countdown slot. An allocation token enters from the lower neighbour,
// is taken if the slot is free, and is otherwise handed on the next cycle.
// ============================================================================
`default_nettype none

module sdtp_cell
    import sdtp_pkg::*;
#(
    parameter int COUNT_WIDTH = 24,
    parameter int CELL_INDEX  = 0
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_token,
    input  wire t_cell_ctrl             i_ctrl,
    input  wire logic [COUNT_WIDTH-1:0] i_delay,
    output logic                        o_token,
    output logic                        o_grab,
    output logic                        o_expired
);

    logic                   r_token;
    logic                   r_busy;
    logic                   r_expired;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   n_busy;
    logic                   n_expired;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   w_release;

    // The token is taken by a free slot and passed on by a busy one.
    assign o_grab    = r_token && !r_busy;
    assign o_token   = r_token && r_busy;
    assign o_expired = r_expired;

    assign w_release = i_ctrl.rel_en && (int'(i_ctrl.slot_index) == CELL_INDEX);

    // Next slot state for allocation, tick and release.
    always_comb begin
        n_busy    = r_busy;
        n_expired = r_expired;
        n_count   = r_count;
        if (o_grab) begin
            n_busy    = 1'b1;
            n_expired = 1'b0;
            n_count   = i_delay;
        end else if (w_release) begin
            n_busy    = 1'b0;
            n_expired = 1'b0;
            n_count   = '0;
        end else if (i_ctrl.tick && r_busy) begin
            if (r_count != '0) begin
                n_count = r_count - COUNT_WIDTH'(1);
            end
            if (n_count == '0) begin
                n_expired = 1'b1;
            end
        end
    end

    // Slot registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token   <= 1'b0;
            r_busy    <= 1'b0;
            r_expired <= 1'b0;
            r_count   <= '0;
        end else begin
            r_token   <= i_token;
            r_busy    <= n_busy;
            r_expired <= n_expired;
            r_count   <= n_count;
        end
    end

endmodule

`default_nettype wire

/* sv/software_delay_timer_pool.sv */
// ============================================================================
// Software delay timer pool
// A row of countdown slot cells with a tick divider and a command sequencer.
// ============================================================================
// Usage:
// A command transaction is accepted on a rising edge with start high and
// busy low. Tick decrements every busy slot and advances the period
// divider, allocate takes the lowest free slot, release frees slot_index,
// and clear drops the sticky period flag.
// Exactly one result follows each command, shown on o_result for a single
// cycle with o_result_valid high; the receiver cannot hold it off.
// Tick, release and clear pass through the apply and report states before
// their result is shown. An allocate sends a token along the row of cells,
// one cell per cycle, and reports once a free cell takes it or it leaves
// the last cell, so its result waits on the token hop through the cell row.
// A new command may be accepted in the cycle its result is shown.
// The period register is written through the cfg channel, which is always
// ready. Reset frees all slots, clears the divider and the flag, and loads
// a period of 500 ticks.
// ============================================================================
`default_nettype none

module software_delay_timer_pool
    import sdtp_pkg::*;
#(
    parameter int NUM_SLOTS   = 16,
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire t_cmd_item           i_item,
    output logic                     busy,
    output logic                     o_result_valid,
    output t_result_item             o_result,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [PERIOD_W-1:0] i_cfg_data
);

    localparam int POS_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_APPLY  = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_REPORT = 2'd3;

    logic [1:0]             r_state;
    t_cmd_item              r_item;
    logic [POS_W-1:0]       r_pos;
    logic                   r_granted;
    logic [INDEX_W-1:0]     r_gslot;
    logic [PERIOD_W-1:0]    r_period;
    logic [PERIOD_W-1:0]    r_pcount;
    logic                   r_flag;
    logic                   r_out_valid;
    t_result_item           r_out;

    logic                   w_accept;
    logic [PERIOD_W:0]      w_pnext;
    logic                   w_wrap;
    logic                   w_slot_done;
    logic                   w_grab_any;
    t_cell_ctrl             w_ctrl;
    logic [COUNT_WIDTH-1:0] w_delay;
    logic [NUM_SLOTS:0]     w_token_link;
    logic [NUM_SLOTS-1:0]   w_grab;
    logic [NUM_SLOTS-1:0]   w_expired;

    assign busy           = (r_state != ST_IDLE);
    assign w_accept       = start && !busy;
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // Broadcast controls, valid during the apply cycle.
    assign w_ctrl.tick       = (r_state == ST_APPLY) && (r_item.command == CMD_TICK);
    assign w_ctrl.rel_en     = (r_state == ST_APPLY) && (r_item.command == CMD_RELEASE);
    assign w_ctrl.slot_index = r_item.slot_index;
    assign w_delay           = COUNT_WIDTH'(r_item.delay_ticks);

    // An allocate injects the token into the first cell on acceptance.
    assign w_token_link[0] = w_accept && (i_item.command == CMD_ALLOC);
    assign w_grab_any      = |w_grab;

    // Row of slot cells.
    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
        sdtp_cell #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .CELL_INDEX  (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_token   (w_token_link[k]),
            .i_ctrl    (w_ctrl),
            .i_delay   (w_delay),
            .o_token   (w_token_link[k+1]),
            .o_grab    (w_grab[k]),
            .o_expired (w_expired[k])
        );
    end

    // Period divider compare.
    assign w_pnext = {1'b0, r_pcount} + (PERIOD_W+1)'(1);
    assign w_wrap  = (w_pnext >= {1'b0, r_period});

    // Done mark of the addressed slot; slots beyond the pool read as zero.
    always_comb begin
        w_slot_done = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (k == int'(r_item.slot_index)) begin
                w_slot_done = w_expired[k];
            end
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_period <= i_cfg_data;
        end
    end

    // Command sequencer, divider and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_granted   <= 1'b0;
            r_gslot     <= '0;
            r_pcount    <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_item    <= i_item;
                        r_pos     <= '0;
                        r_granted <= 1'b0;
                        r_gslot   <= '0;
                        if (i_item.command == CMD_ALLOC) begin
                            r_state <= ST_SEARCH;
                        end else begin
                            r_state <= ST_APPLY;
                        end
                    end
                end
                ST_APPLY: begin
                    if (r_item.command == CMD_TICK) begin
                        if (w_wrap) begin
                            r_pcount <= '0;
                            r_flag   <= 1'b1;
                        end else begin
                            r_pcount <= w_pnext[PERIOD_W-1:0];
                        end
                    end else if (r_item.command == CMD_CLEAR) begin
                        r_flag <= 1'b0;
                    end
                    r_state <= ST_REPORT;
                end
                ST_SEARCH: begin
                    if (w_grab_any) begin
                        r_granted <= 1'b1;
                        r_gslot   <= INDEX_W'(r_pos);
                        r_state   <= ST_REPORT;
                    end else if (w_token_link[NUM_SLOTS]) begin
                        r_state <= ST_REPORT;
                    end else begin
                        r_pos <= r_pos + POS_W'(1);
                    end
                end
                ST_REPORT: begin
                    r_out_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Result payload, captured as the report cycle ends.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_REPORT) begin
            r_out.granted      <= r_granted;
            r_out.granted_slot <= r_gslot;
            r_out.slot_done    <= w_slot_done;
            r_out.period_flag  <= r_flag;
        end
    end

endmodule

`default_nettype wire

/* sv/sdtp_checker.sv */
// ============================================================================
// Delay timer pool port checker
// Watches the top-level ports for command and result sequencing faults.
// ============================================================================
`default_nettype none

module sdtp_checker
    import sdtp_pkg::*;
(
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         start,
    input wire logic         busy,
    input wire logic         o_result_valid,
    input wire t_result_item o_result
);

    // An accepted command keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // A result is only shown once the command is finished.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    // Each command yields a single one-cycle result.
    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // A result without a grant, such as a refused allocation, reports slot zero.
    a_refused_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.granted) |-> (o_result.granted_slot == '0))
        else $error("granted_slot nonzero without a grant");

endmodule

bind software_delay_timer_pool sdtp_checker u_sdtp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

`default_nettype wire

/* tb/software_delay_timer_pool_tb.sv */
// ============================================================================
// Delay timer pool testbench
// Drives command transactions into the timer pool with random gaps, keeps a
// command-level picture of every slot, the tick divider and the sticky flag,
// and checks each result transaction against that picture in order. A short
// directed sequence covers zero delays, countdown to done, release, a full
// pool and the divider edges. Long random phases under several periods
// follow.
// ============================================================================

module software_delay_timer_pool_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdtp_pkg::*;

    localparam int NUM_SLOTS     = 16;
    localparam int COUNT_WIDTH   = 24;
    localparam int MAX_GAP       = 5;
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 210;
    localparam int MAX_PRINTED   = 50;
    localparam int CMD_W         = $bits(t_cmd_item);

    // Block ports.
    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    t_cmd_item           i_item;
    logic                busy;
    logic                o_result_valid;
    t_result_item        o_result;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [PERIOD_W-1:0] i_cfg_data;

    // Picture of the pool state as the block should hold it.
    logic [COUNT_WIDTH-1:0] slot_left [NUM_SLOTS];
    bit                     slot_taken [NUM_SLOTS];
    bit                     slot_fired [NUM_SLOTS];
    logic [PERIOD_W-1:0]    tick_phase;
    logic [PERIOD_W-1:0]    tick_period;
    bit                     period_seen;

    // Status transactions still owed by the block, oldest first.
    t_result_item pool_status_q[$];

    int error_count;
    int cycle_count;
    bit no_gaps;

    software_delay_timer_pool #(
        .NUM_SLOTS   (NUM_SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_item         (i_item),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // Free-running clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Counts a mismatch and prints it, up to a cap on printed lines.
    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("ERROR at %0t ns: %s", $realtime, msg);
        end
    endtask

    // Applies one command to the pool picture and returns the status it yields.
    function automatic t_result_item pool_command_effect(input t_cmd_item cmd);
        t_result_item           status;
        logic [PERIOD_W:0]      next_phase;
        bit                     placed;
        status = '0;
        placed = 1'b0;
        case (cmd.command)
            CMD_TICK: begin
                // The divider compare is done one bit wider so that it never wraps.
                next_phase = {1'b0, tick_phase} + 1'b1;
                if (next_phase >= {1'b0, tick_period}) begin
                    tick_phase  = '0;
                    period_seen = 1'b1;
                end else begin
                    tick_phase = next_phase[PERIOD_W-1:0];
                end
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    if (slot_taken[k] && slot_left[k] != '0) begin
                        slot_left[k] = slot_left[k] - 1'b1;
                    end
                    if (slot_taken[k] && slot_left[k] == '0) begin
                        slot_fired[k] = 1'b1;
                    end
                end
            end
            CMD_ALLOC: begin
                // The lowest free slot wins; a full pool leaves everything alone.
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    if (!placed && !slot_taken[k]) begin
                        slot_left[k]        = cmd.delay_ticks[COUNT_WIDTH-1:0];
                        slot_taken[k]       = 1'b1;
                        slot_fired[k]       = 1'b0;
                        status.granted      = 1'b1;
                        status.granted_slot = INDEX_W'(k);
                        placed              = 1'b1;
                    end
                end
            end
            CMD_RELEASE: begin
                if (cmd.slot_index < NUM_SLOTS) begin
                    slot_left[cmd.slot_index]  = '0;
                    slot_taken[cmd.slot_index] = 1'b0;
                    slot_fired[cmd.slot_index] = 1'b0;
                end
            end
            default: begin
                period_seen = 1'b0;
            end
        endcase
        status.slot_done   = (cmd.slot_index < NUM_SLOTS) ? slot_fired[cmd.slot_index] : 1'b0;
        status.period_flag = period_seen;
        return status;
    endfunction

    // Sends one command transaction after a random gap and records its status.
    task automatic send_cmd(input logic [1:0] command, input logic [DELAY_W-1:0] delay,
                            input logic [INDEX_W-1:0] index);
        t_cmd_item cmd;
        int        gap;
        cmd.command     = command;
        cmd.delay_ticks = delay;
        cmd.slot_index  = index;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge i_clk);
            start  <= 1'b0;
            i_item <= CMD_W'($urandom);
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= cmd;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        pool_status_q.push_back(pool_command_effect(cmd));
    endtask

    // Random command with contents weighted towards short delays and ticks.
    task automatic send_random_cmd();
        int                  pick;
        logic [1:0]          command;
        logic [DELAY_W-1:0]  delay;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            command = CMD_TICK;
        end else if (pick < 72) begin
            command = CMD_ALLOC;
        end else if (pick < 92) begin
            command = CMD_RELEASE;
        end else begin
            command = CMD_CLEAR;
        end
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            delay = DELAY_W'($urandom_range(0, 12));
        end else if (pick < 8) begin
            delay = DELAY_W'($urandom_range(0, 255));
        end else begin
            delay = DELAY_W'($urandom);
        end
        send_cmd(command, delay, INDEX_W'($urandom_range(0, NUM_SLOTS - 1)));
    endtask

    // Lowers start, waits for every owed status and lets the pipeline settle.
    task automatic wait_pool_idle();
        int waited;
        waited = 0;
        @(negedge i_clk);
        start <= 1'b0;
        while (pool_status_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pool_status_q.size() != 0) begin
            report_error($sformatf("%0d results never arrived", pool_status_q.size()));
            pool_status_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the divider period through the configuration channel while idle.
    task automatic write_period(input logic [PERIOD_W-1:0] value);
        wait_pool_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (o_cfg_ready !== 1'b1);
        tick_period = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= PERIOD_W'($urandom);
    endtask

    // A slot loaded with zero is done on the very next tick.
    task automatic test_zero_delay();
        send_cmd(CMD_ALLOC, '0, 4'd0);
        send_cmd(CMD_TICK, '0, 4'd0);
    endtask

    // Countdown to done, and a slot holding the largest count.
    task automatic test_countdown();
        send_cmd(CMD_ALLOC, 24'd1, 4'd1);
        send_cmd(CMD_TICK, 24'hFFFFFF, 4'd1);
        send_cmd(CMD_ALLOC, 24'hFFFFFF, 4'd2);
        send_cmd(CMD_TICK, '0, 4'd2);
    endtask

    // Release clears the done mark, and ticks leave a free slot untouched.
    task automatic test_release();
        send_cmd(CMD_RELEASE, '0, 4'd0);
        send_cmd(CMD_TICK, '0, 4'd0);
    endtask

    // Fill the pool, then one more allocate must be refused.
    task automatic test_pool_full();
        for (int n = 0; n < NUM_SLOTS - 1; n++) begin
            send_cmd(CMD_ALLOC, DELAY_W'($urandom_range(0, 6)), 4'hF);
        end
    endtask

    // Divider at the shortest period, flag clear, and a period lowered below
    // the running divider count.
    task automatic test_divider();
        write_period(16'd1);
        send_cmd(CMD_TICK, '0, 4'd5);
        send_cmd(CMD_CLEAR, '0, 4'd5);
        write_period(16'hFFFF);
        repeat (3) send_cmd(CMD_TICK, '0, 4'd3);
        write_period(16'd2);
        send_cmd(CMD_TICK, '0, 4'd3);
    endtask

    // Random traffic under a range of divider periods.
    task automatic test_random_traffic();
        logic [PERIOD_W-1:0] period_pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: period_pick = 16'd1;
                1: period_pick = 16'hFFFF;
                2: period_pick = PERIOD_RESET;
                3: period_pick = PERIOD_W'($urandom_range(1, 65535));
                default: period_pick = PERIOD_W'($urandom_range(2, 40));
            endcase
            write_period(period_pick);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Every so often switch between gapped and back-to-back traffic.
                if (n % 40 == 0) begin
                    no_gaps = ($urandom_range(0, 3) == 0);
                end
                send_random_cmd();
            end
        end
        no_gaps = 1'b0;
    endtask

    // Compares every result transaction with the oldest owed status.
    always @(posedge i_clk) begin : result_check
        t_result_item want;
        if (i_rst_n && o_result_valid) begin
            if (pool_status_q.size() == 0) begin
                report_error("result with no command outstanding");
            end else begin
                want = pool_status_q.pop_front();
                if (o_result.granted !== want.granted) begin
                    report_error($sformatf("granted %b, want %b",
                                           o_result.granted, want.granted));
                end
                if (o_result.granted_slot !== want.granted_slot) begin
                    report_error($sformatf("granted_slot %0d, want %0d",
                                           o_result.granted_slot, want.granted_slot));
                end
                if (o_result.slot_done !== want.slot_done) begin
                    report_error($sformatf("slot_done %b, want %b",
                                           o_result.slot_done, want.slot_done));
                end
                if (o_result.period_flag !== want.period_flag) begin
                    report_error($sformatf("period_flag %b, want %b",
                                           o_result.period_flag, want.period_flag));
                end
            end
        end
    end

    // Ends a run that has stopped making progress.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Reset, the directed tests, the random phases, then the verdict.
    initial begin
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        error_count = 0;
        no_gaps     = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            slot_left[k]  = '0;
            slot_taken[k] = 1'b0;
            slot_fired[k] = 1'b0;
        end
        tick_phase  = '0;
        tick_period = PERIOD_RESET;
        period_seen = 1'b0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_delay();
        test_countdown();
        test_release();
        test_pool_full();
        test_divider();
        test_random_traffic();

        wait_pool_idle();
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
